// File: src/tdp_pkg.sv
// Shared types and constants for the trial division prime test unit.
package tdp_pkg;

  localparam int DEFAULT_VALUE_BITS = 32;
  localparam int QUEUE_DEPTH        = 2;
  localparam int FIRST_DIVISOR      = 3;
  localparam int DIVISOR_STEP       = 2;

  typedef struct packed {
    logic needs_test;
    logic quick;
  } class_t;

  localparam int CLASS_BITS = $bits(class_t);

  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CHECK,
    B_DIVIDE,
    B_FINISH
  } back_state_t;

endpackage

// File: src/tdp_in_if.sv
// Input channel interface: value to classify.
interface tdp_in_if #(
  parameter int VALUE_BITS = tdp_pkg::DEFAULT_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: src/tdp_out_if.sv
// Result channel interface: prime flag.
interface tdp_out_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

// File: src/trial_division_prime_test_unit.sv
// Top level of the trial division prime test unit.
//
//   channel  dir  payload                 transaction
//   in_ch    in   value [VALUE_BITS] s    valid & ready
//   out_ch   out  is_prime [1]            valid & ready
//
// Values that are negative, below four or even are settled by the front end and pass
// through the queue and the back end with no trial. Odd values of five or more try
// odd divisors from three while d*d <= value; each trial runs the remainder unit, which
// takes one bit per cycle, and an item needs up to about 23170 trials at 32 bits.
// Synchronous active-low reset empties the queue and idles both ends; no clearing pass.
// The front end keeps accepting into the two-entry queue, until it is full, while the
// back end or the result register is stalled.
module trial_division_prime_test_unit #(
  parameter int VALUE_BITS = tdp_pkg::DEFAULT_VALUE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  tdp_in_if.sink    in_ch,
  tdp_out_if.source out_ch
);

  localparam int ENTRY_BITS = VALUE_BITS + tdp_pkg::CLASS_BITS;

  logic                  push_valid, push_ready;
  logic [ENTRY_BITS-1:0] push_data;
  logic                  pop_valid, pop_ready;
  logic [ENTRY_BITS-1:0] pop_data;
  logic                  mod_start;
  logic [VALUE_BITS-1:0] mod_dividend, mod_divisor;
  tdp_pkg::mod_status_t  mod_status;

  tdp_front #(
    .VALUE_BITS(VALUE_BITS),
    .ENTRY_BITS(ENTRY_BITS)
  ) u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  tdp_queue #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(tdp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  tdp_mod_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .status   (mod_status)
  );

  tdp_back #(
    .VALUE_BITS(VALUE_BITS),
    .ENTRY_BITS(ENTRY_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_data     (pop_data),
    .pop_ready    (pop_ready),
    .mod_start    (mod_start),
    .mod_dividend (mod_dividend),
    .mod_divisor  (mod_divisor),
    .mod_status   (mod_status),
    .out_ch       (out_ch)
  );

  a_no_start_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    mod_status.done |-> !mod_start)
    else $error("remainder unit restarted while reporting");

  a_start_not_done_next: assert property (@(posedge clk) disable iff (!rst_n)
    mod_start |=> !mod_status.done)
    else $error("remainder unit finished one cycle after start");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    mod_status.done |=> !mod_status.done)
    else $error("remainder done held for more than one cycle");

  a_no_pop_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    mod_start |=> !pop_ready)
    else $error("queue popped during a trial division");

endmodule

// File: src/tdp_front.sv
// Front end: accept values, classify the ones that need no trial division and mark the rest for testing.
module tdp_front #(
  parameter int VALUE_BITS = tdp_pkg::DEFAULT_VALUE_BITS,
  parameter int ENTRY_BITS = VALUE_BITS + tdp_pkg::CLASS_BITS
) (
  tdp_in_if.sink               in_ch,
  output logic                 push_valid,
  output logic [ENTRY_BITS-1:0] push_data,
  input  logic                 push_ready
);

  logic [VALUE_BITS-1:0] v;
  tdp_pkg::class_t       cls;

  assign v = VALUE_BITS'(in_ch.value);

  always_comb begin
    cls.needs_test = 1'b0;
    cls.quick      = 1'b0;
    if (v[VALUE_BITS-1]) begin
      cls.quick = 1'b0;
    end else if (v < VALUE_BITS'(2)) begin
      cls.quick = 1'b0;
    end else if (v < VALUE_BITS'(4)) begin
      cls.quick = 1'b1;
    end else if (!v[0]) begin
      cls.quick = 1'b0;
    end else begin
      cls.needs_test = 1'b1;
    end
  end

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign push_data   = {v, cls};

endmodule

// File: src/tdp_queue.sv
// Short FIFO between the front end and the back end.
module tdp_queue #(
  parameter int WIDTH = 34,
  parameter int DEPTH = tdp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data,
  input  logic             pop_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/tdp_mod_unit.sv
// Iterative remainder unit: one restoring step per cycle, remainder zero flag at the end.
module tdp_mod_unit #(
  parameter int VALUE_BITS = tdp_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output tdp_pkg::mod_status_t  status
);

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] shreg_r, shreg_nxt;
  logic [VALUE_BITS:0]   rem_r, rem_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   div_ext;

  assign trial   = {rem_r[VALUE_BITS-1:0], shreg_r[VALUE_BITS-1]};
  assign div_ext = {1'b0, divisor};

  always_comb begin
    shreg_nxt = shreg_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      shreg_nxt = dividend;
      rem_nxt   = '0;
      cnt_nxt   = CW'(VALUE_BITS);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      shreg_nxt = {shreg_r[VALUE_BITS-2:0], 1'b0};
      rem_nxt   = (trial >= div_ext) ? trial - div_ext : trial;
      cnt_nxt   = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
    rem_r   <= rem_nxt;
  end

  assign status.done     = done_r;
  assign status.rem_zero = (rem_r == '0);

endmodule

// File: src/tdp_back.sv
// Back end: walk odd divisors up to the square root and drive the result register.
module tdp_back #(
  parameter int VALUE_BITS = tdp_pkg::DEFAULT_VALUE_BITS,
  parameter int ENTRY_BITS = VALUE_BITS + tdp_pkg::CLASS_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  input  logic [ENTRY_BITS-1:0] pop_data,
  output logic                  pop_ready,
  output logic                  mod_start,
  output logic [VALUE_BITS-1:0] mod_dividend,
  output logic [VALUE_BITS-1:0] mod_divisor,
  input  tdp_pkg::mod_status_t  mod_status,
  tdp_out_if.source             out_ch
);

  tdp_pkg::back_state_t  state_r, state_nxt;
  logic [VALUE_BITS-1:0] n_r, n_nxt;
  logic [VALUE_BITS-1:0] d_r, d_nxt;
  logic [VALUE_BITS:0]   sq_r, sq_nxt;
  logic                  res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_prime_r, out_prime_nxt;
  logic                  slot_free;
  tdp_pkg::class_t       cls;
  logic [VALUE_BITS-1:0] entry_value;

  assign cls         = tdp_pkg::class_t'(pop_data[tdp_pkg::CLASS_BITS-1:0]);
  assign entry_value = pop_data[ENTRY_BITS-1:tdp_pkg::CLASS_BITS];
  assign slot_free   = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdp_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    res_r       <= res_nxt;
    out_prime_r <= out_prime_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_prime_nxt = out_prime_r;
    pop_ready     = 1'b0;
    mod_start     = 1'b0;
    case (state_r)
      tdp_pkg::B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          n_nxt  = entry_value;
          d_nxt  = VALUE_BITS'(tdp_pkg::FIRST_DIVISOR);
          sq_nxt = (VALUE_BITS + 1)'(tdp_pkg::FIRST_DIVISOR * tdp_pkg::FIRST_DIVISOR);
          if (cls.needs_test) begin
            state_nxt = tdp_pkg::B_CHECK;
          end else begin
            res_nxt   = cls.quick;
            state_nxt = tdp_pkg::B_FINISH;
          end
        end
      end
      tdp_pkg::B_CHECK: begin
        if (sq_r > {1'b0, n_r}) begin
          res_nxt   = 1'b1;
          state_nxt = tdp_pkg::B_FINISH;
        end else begin
          mod_start = 1'b1;
          state_nxt = tdp_pkg::B_DIVIDE;
        end
      end
      tdp_pkg::B_DIVIDE: begin
        if (mod_status.done) begin
          if (mod_status.rem_zero) begin
            res_nxt   = 1'b0;
            state_nxt = tdp_pkg::B_FINISH;
          end else begin
            // advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4
            d_nxt     = d_r + VALUE_BITS'(tdp_pkg::DIVISOR_STEP);
            sq_nxt    = sq_r + {d_r[VALUE_BITS-2:0], 2'b00}
                        + (VALUE_BITS + 1)'(tdp_pkg::DIVISOR_STEP * tdp_pkg::DIVISOR_STEP);
            state_nxt = tdp_pkg::B_CHECK;
          end
        end
      end
      tdp_pkg::B_FINISH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = res_r;
          state_nxt     = tdp_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = tdp_pkg::B_IDLE;
      end
    endcase
  end

  assign mod_dividend    = n_r;
  assign mod_divisor     = d_r;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.is_prime = out_prime_r;

endmodule

// File: tb/trial_division_prime_test_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the trial division prime test unit: corner and random values.
module trial_division_prime_test_unit_test;

  localparam int VALUE_BITS   = tdp_pkg::DEFAULT_VALUE_BITS;
  localparam int TRIAL_CYCLES = VALUE_BITS + 2;
  localparam int RANDOM_COUNT = 77;
  localparam int CALM_TAIL    = 15;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_BURST    = 16;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  is_prime;
  } verdict_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tdp_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  tdp_out_if out_ch ();

  trial_division_prime_test_unit #(.VALUE_BITS(VALUE_BITS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  verdict_t pending_values[$];
  verdict_t awaited_verdicts[$];
  verdict_t in_flight;
  int       send_gap       = 0;
  int       recv_stall     = 0;
  int       accepted       = 0;
  int       checked        = 0;
  int       primes_seen    = 0;
  int       negatives_seen = 0;
  int       failures       = 0;
  int       directed_count = 0;
  int       total_values   = 0;
  bit       calm           = 1'b0;
  longint   cycle_count    = 0;
  longint   cycle_budget   = 0;
  longint   cycle_limit    = 64'd100_000_000;

  function automatic logic primality_of(input logic [VALUE_BITS-1:0] value, output int trials);
    longint unsigned n;
    longint unsigned d;
    logic            prime;
    trials = 0;
    n      = {{(64-VALUE_BITS){1'b0}}, value};
    if (value[VALUE_BITS-1] || n < 2) begin
      prime = 1'b0;
    end else if (n < 4) begin
      prime = 1'b1;
    end else if (n[0] == 1'b0) begin
      prime = 1'b0;
    end else begin
      prime = 1'b1;
      d     = 3;
      while (prime && d <= n / d) begin
        trials++;
        if (n % d == 0) prime = 1'b0;
        d += 2;
      end
    end
    return prime;
  endfunction

  task automatic queue_value(input logic [VALUE_BITS-1:0] value);
    verdict_t entry;
    int       trials;
    entry.value    = value;
    entry.is_prime = primality_of(value, trials);
    pending_values.push_back(entry);
    cycle_budget += 3 + TRIAL_CYCLES * (trials + 2) + 2 * MAX_BURST;
  endtask

  initial forever #2 clk = ~clk;

  // Driver: hold the value until the transaction completes, then load the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
      send_gap    <= 0;
      calm        <= 1'b0;
    end else begin
      calm <= (pending_values.size() <= CALM_TAIL);
      if (in_ch.valid && in_ch.ready) begin
        awaited_verdicts.push_back(in_flight);
        accepted <= accepted + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          in_ch.valid <= 1'b0;
          send_gap    <= send_gap - 1;
        end else if (pending_values.size() > 0) begin
          in_flight = pending_values.pop_front();
          in_ch.value <= in_flight.value;
          in_ch.valid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, MAX_BURST);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall in bursts until the quiet tail of the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall   <= 0;
    end else if (recv_stall > 0) begin
      out_ch.ready <= 1'b0;
      recv_stall   <= recv_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) recv_stall <= $urandom_range(1, MAX_BURST);
    end
  end

  always @(posedge clk) begin
    verdict_t oldest;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_verdicts.size() == 0) begin
        $error("is_prime: expected nothing, actual %0b", out_ch.is_prime);
        failures = failures + 1;
      end else begin
        oldest = awaited_verdicts.pop_front();
        checked = checked + 1;
        if (oldest.is_prime) primes_seen = primes_seen + 1;
        if (oldest.value[VALUE_BITS-1]) negatives_seen = negatives_seen + 1;
        if (out_ch.is_prime !== oldest.is_prime) begin
          $error("is_prime: expected %0b, actual %0b (value %0d)",
                 oldest.is_prime, out_ch.is_prime, $signed(oldest.value));
          failures = failures + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("timed out after %0d cycles with %0d results outstanding",
               cycle_count, awaited_verdicts.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [VALUE_BITS-1:0] value;
    int                    factor;
    int unsigned           multiple;

    queue_value(32'h8000_0000);
    queue_value(32'hFFFF_FFFF);
    queue_value(32'hFFFF_FFFE);
    queue_value(32'hFFFF_FFF9);
    queue_value(32'd0);
    queue_value(32'd1);
    queue_value(32'd2);
    queue_value(32'd3);
    queue_value(32'd4);
    queue_value(32'd5);
    queue_value(32'd9);
    queue_value(32'd25);
    queue_value(32'd49);
    queue_value(32'd97);
    queue_value(32'd121);
    queue_value(32'd169);
    queue_value(32'd65521);
    queue_value(32'd65537);
    queue_value(32'h4000_0000);
    queue_value(32'h3FFF_FFFF);
    queue_value(32'h7FFF_FFFE);
    queue_value(32'h7FFF_FFFD);
    queue_value(32'h7FFF_FFFF);
    directed_count = pending_values.size();

    // Keep large positive values cheap: give them a small odd factor.
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      case ($urandom_range(0, 7))
        0, 1, 2: value = $urandom_range(0, 1023);
        3, 4:    value = $urandom_range(1024, 65535) | 32'h1;
        5: begin
          factor   = 3 + 2 * $urandom_range(0, 15);
          multiple = $urandom_range(1, 32'h7FFF_FFFF / factor);
          value    = factor * multiple;
        end
        6:       value = $urandom | 32'h8000_0000;
        default: value = $urandom & ~32'h1;
      endcase
      queue_value(value);
    end
    total_values = pending_values.size();
    cycle_limit  = 4 * cycle_budget + 10000;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted != total_values) @(posedge clk);
    while (awaited_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d values classified (%0d corner cases, %0d random) in %0d cycles",
             checked, directed_count, total_values - directed_count, cycle_count);
    $display("%0d were prime, %0d were negative", primes_seen, negatives_seen);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: trial_division_prime_test_unit.f
src/tdp_pkg.sv
src/tdp_in_if.sv
src/tdp_out_if.sv
src/tdp_front.sv
src/tdp_queue.sv
src/tdp_mod_unit.sv
src/tdp_back.sv
src/trial_division_prime_test_unit.sv
tb/trial_division_prime_test_unit_test.sv
